// File: hdl/chan_tangent_wrap_step_assert.svh
// Assertion macros shared by the tangent wrap step RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CHAN_TANGENT_WRAP_STEP_ASSERT_SVH
`define CHAN_TANGENT_WRAP_STEP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CTWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CTWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/ctws_pkg.sv
// Shared types and constants for the tangent wrap step block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctws_pkg;

  localparam int MAX_GROUP_DEF = 64;

  // coordinate, difference, product and cross/distance widths
  localparam int CRD_W = 16;
  localparam int DW    = CRD_W + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = PW + 1;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;

  typedef struct packed {
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] x;
  } point_t;

endpackage

`default_nettype wire

// File: hdl/ctws_vbuf.sv
// Vertex buffer: single-port-write, single-port-read synchronous memory.
// Read data is registered and held until the next read. Uses ctws_pkg.
`default_nettype none

module ctws_vbuf import ctws_pkg::*; #(
  parameter int DEPTH = MAX_GROUP_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire point_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output point_t             rd_data
);

  point_t mem_r [DEPTH];
  point_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

`default_nettype wire

// File: hdl/ctws_mul2.sv
// Dual signed multiplier with registered products, shared by the scan and
// the merge of the tangent wrap step. Uses ctws_pkg for widths.
`default_nettype none

module ctws_mul2 import ctws_pkg::*; (
  input  wire logic                 clk,
  input  wire logic signed [DW-1:0] a0,
  input  wire logic signed [DW-1:0] b0,
  input  wire logic signed [DW-1:0] a1,
  input  wire logic signed [DW-1:0] b1,
  output logic signed [PW-1:0]      p0,
  output logic signed [PW-1:0]      p1
);

  logic signed [PW-1:0] p0_r;
  logic signed [PW-1:0] p1_r;

  always_ff @(posedge clk) begin
    p0_r <= PW'(a0) * PW'(b0);
    p1_r <= PW'(a1) * PW'(b1);
  end

  assign p0 = p0_r;
  assign p1 = p1_r;

endmodule

`default_nettype wire

// File: hdl/chan_tangent_wrap_step.sv
// Top level of the tangent wrap step: control sequencer, reference registers,
// running best and output register. Uses ctws_pkg, ctws_vbuf, ctws_mul2.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes ref_x
//    (index 0) and ref_y (index 1); cfg_ready is always high, other indexes
//    are ignored. Write only while no group is being processed.
//  - in channel: one word per vertex, x and y in tdata, tuser marks the end
//    of a sub-hull, tlast marks the end of the whole set (and of its group).
//  - out channel: one word per set, carrying the chosen next hull point.
// Sequencing (a vertex that does not end a group is just stored in S_IDLE):
//  - a group end of n >= 2 vertices runs the scan: S_START, S_FETCH0,
//    then S_MUL and S_EVAL per edge until the tangent. The scan is paced
//    by the registered multiplier: each edge takes one multiply and one
//    check. A group of one vertex skips the scan. Then comes the merge:
//    S_MERGE, plus S_MC to S_MD when a best exists and tan is not the ref.
//  - on a set end S_EMIT then loads the output register.
// Reset clears the fill count, running best, reference and output valid;
// the vertex buffer holds no reset and needs no clearing pass.
// A stalled receiver holds the result in the output register; input words
// are still taken until another set end needs the register.
`default_nettype none
`include "chan_tangent_wrap_step_assert.svh"

module chan_tangent_wrap_step import ctws_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CRD_W-1:0]     cfg_data,
  // vertex stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,  // point_x[15:0], point_y[31:16]
  input  wire logic [0:0]           in_tuser,  // group_last[0]
  input  wire logic                 in_tlast,  // set_last
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata  // next_x[15:0], next_y[31:16]
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int NW = $clog2(MAX_GROUP + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FETCH0,
    S_MUL,
    S_EVAL,
    S_MERGE,
    S_MC,
    S_MT,
    S_MB,
    S_MD,
    S_EMIT
  } state_t;

  function automatic logic signed [DW-1:0] sdiff(input logic signed [CRD_W-1:0] a,
                                                 input logic signed [CRD_W-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  // registers
  state_t                  state_r,      state_nxt;
  logic [NW-1:0]           fill_r,       fill_nxt;
  logic [NW-1:0]           n_r,          n_nxt;
  logic                    set_end_r,    set_end_nxt;
  point_t                  first_r,      first_nxt;
  point_t                  prev_r,       prev_nxt;
  point_t                  tan_r,        tan_nxt;
  point_t                  best_r,       best_nxt;
  logic                    best_valid_r, best_valid_nxt;
  logic                    prime_r,      prime_nxt;
  logic                    edge_nn_r,    edge_nn_nxt;
  logic [AW-1:0]           k_r,          k_nxt;
  logic [AW-1:0]           rd_addr_r,    rd_addr_nxt;
  logic signed [CW-1:0]    cross_r,      cross_nxt;
  logic signed [CW-1:0]    dt_r,         dt_nxt;
  logic signed [CRD_W-1:0] ref_x_r,      ref_x_nxt;
  logic signed [CRD_W-1:0] ref_y_r,      ref_y_nxt;
  logic                    out_valid_r,  out_valid_nxt;
  point_t                  out_data_r,   out_data_nxt;

  // datapath signals
  point_t               in_pt;
  point_t               ref_pt;
  point_t               rd_data;
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 has_room;
  logic [NW-1:0]        n_in;
  logic [NW-1:0]        n_m1;
  logic [AW-1:0]        last_addr;
  logic [AW-1:0]        wrap_addr;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic signed [DW-1:0] a0, b0, a1, b1;
  logic signed [PW-1:0] p0, p1;
  logic signed [CW-1:0] prod_diff;
  logic signed [CW-1:0] prod_sum;
  logic                 prev_is_ref;
  logic                 tan_is_ref;
  logic                 out_free;

  assign in_pt     = point_t'(in_tdata);
  assign ref_pt    = '{y: ref_y_r, x: ref_x_r};
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // buffer occupancy; vertices past the end are dropped
  assign has_room  = (fill_r < NW'(MAX_GROUP));
  assign n_in      = has_room ? fill_r + NW'(1) : fill_r;
  assign n_m1      = n_r - NW'(1);
  assign last_addr = n_m1[AW-1:0];
  assign wrap_addr = (rd_addr_r == last_addr) ? '0 : rd_addr_r + AW'(1);

  // fetch the next vertex while the current edge is checked, so the read
  // data holds the current vertex through both multiply and check
  assign wr_en   = in_fire && has_room;
  assign rd_en   = (state_r == S_START) || (state_r == S_FETCH0) || (state_r == S_EVAL);
  assign rd_addr = (state_r == S_START) ? last_addr : wrap_addr;

  ctws_vbuf #(
    .DEPTH (MAX_GROUP),
    .AW    (AW)
  ) u_vbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_pt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Operand select for the shared multiplier pair.
  // Cross terms: P = first point - ref, Q = second point - ref,
  // cross = Py*Qx - Px*Qy. Distance terms square one point's offsets.
  always_comb begin
    a0 = sdiff(best_r.y, ref_y_r);
    b0 = sdiff(tan_r.x,  ref_x_r);
    a1 = sdiff(best_r.x, ref_x_r);
    b1 = sdiff(tan_r.y,  ref_y_r);
    case (state_r)
      S_MUL: begin
        a0 = sdiff(prev_r.y,  ref_y_r);
        b0 = sdiff(rd_data.x, ref_x_r);
        a1 = sdiff(prev_r.x,  ref_x_r);
        b1 = sdiff(rd_data.y, ref_y_r);
      end
      S_MT: begin
        a0 = sdiff(tan_r.x, ref_x_r);
        b0 = sdiff(tan_r.x, ref_x_r);
        a1 = sdiff(tan_r.y, ref_y_r);
        b1 = sdiff(tan_r.y, ref_y_r);
      end
      S_MB: begin
        a0 = sdiff(best_r.x, ref_x_r);
        b0 = sdiff(best_r.x, ref_x_r);
        a1 = sdiff(best_r.y, ref_y_r);
        b1 = sdiff(best_r.y, ref_y_r);
      end
      default: begin
      end
    endcase
  end

  ctws_mul2 u_mul2 (
    .clk (clk),
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .p0  (p0),
    .p1  (p1)
  );

  assign prod_diff   = CW'(p0) - CW'(p1);
  assign prod_sum    = CW'(p0) + CW'(p1);
  assign prev_is_ref = (prev_r == ref_pt);
  assign tan_is_ref  = (tan_r == ref_pt);
  assign out_free    = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    n_nxt          = n_r;
    set_end_nxt    = set_end_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    tan_nxt        = tan_r;
    best_nxt       = best_r;
    best_valid_nxt = best_valid_r;
    prime_nxt      = prime_r;
    edge_nn_nxt    = edge_nn_r;
    k_nxt          = k_r;
    rd_addr_nxt    = rd_addr_r;
    cross_nxt      = cross_r;
    dt_nxt         = dt_r;
    ref_x_nxt      = ref_x_r;
    ref_y_nxt      = ref_y_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    // drop the output word once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      case (cfg_index)
        REG_REF_X: ref_x_nxt = cfg_data;
        REG_REF_Y: ref_y_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    if (rd_en) begin
      rd_addr_nxt = rd_addr;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (fill_r == '0) begin
            first_nxt = in_pt;
          end
          if (in_tuser[0] || in_tlast) begin
            n_nxt       = n_in;
            fill_nxt    = '0;
            set_end_nxt = in_tlast;
            if (n_in == NW'(1)) begin
              // a lone vertex is its own tangent
              tan_nxt   = in_pt;
              state_nxt = S_MERGE;
            end else begin
              state_nxt = S_START;
            end
          end else begin
            fill_nxt = n_in;
          end
        end
      end
      S_START: begin
        prime_nxt = 1'b1;
        k_nxt     = '0;
        state_nxt = S_FETCH0;
      end
      S_FETCH0: begin
        prev_nxt  = rd_data;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // edge from prev to the vertex held in rd_data
        edge_nn_nxt = !prod_diff[CW-1];
        prev_nxt    = rd_data;
        state_nxt   = S_MUL;
        if (prime_r) begin
          prime_nxt = 1'b0;
        end else if (!prev_is_ref && (prod_diff <= 0) && edge_nn_r) begin
          tan_nxt   = prev_r;
          state_nxt = S_MERGE;
        end else if (k_r == last_addr) begin
          // no vertex qualified: fall back to the first one
          tan_nxt   = first_r;
          state_nxt = S_MERGE;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      S_MERGE: begin
        if (!best_valid_r) begin
          best_nxt       = tan_r;
          best_valid_nxt = 1'b1;
          state_nxt      = set_end_r ? S_EMIT : S_IDLE;
        end else if (tan_is_ref) begin
          state_nxt = set_end_r ? S_EMIT : S_IDLE;
        end else begin
          state_nxt = S_MC;
        end
      end
      S_MC: begin
        state_nxt = S_MT;
      end
      S_MT: begin
        cross_nxt = prod_diff;
        state_nxt = S_MB;
      end
      S_MB: begin
        dt_nxt    = prod_sum;
        state_nxt = S_MD;
      end
      S_MD: begin
        // positive turn, or collinear and strictly nearer
        if ((cross_r > 0) || ((cross_r == 0) && (dt_r < prod_sum))) begin
          best_nxt = tan_r;
        end
        state_nxt = set_end_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          out_data_nxt   = best_r;
          out_valid_nxt  = 1'b1;
          best_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      best_r       <= '0;
      best_valid_r <= 1'b0;
      ref_x_r      <= '0;
      ref_y_r      <= '0;
      out_valid_r  <= 1'b0;
      set_end_r    <= 1'b0;
      prime_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      best_r       <= best_nxt;
      best_valid_r <= best_valid_nxt;
      ref_x_r      <= ref_x_nxt;
      ref_y_r      <= ref_y_nxt;
      out_valid_r  <= out_valid_nxt;
      set_end_r    <= set_end_nxt;
      prime_r      <= prime_nxt;
    end
    n_r        <= n_nxt;
    first_r    <= first_nxt;
    prev_r     <= prev_nxt;
    tan_r      <= tan_nxt;
    edge_nn_r  <= edge_nn_nxt;
    k_r        <= k_nxt;
    rd_addr_r  <= rd_addr_nxt;
    cross_r    <= cross_nxt;
    dt_r       <= dt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CTWS_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= NW'(MAX_GROUP))
  `CTWS_ASSERT_IMP(a_scan_needs_two, state_r == S_START, n_r >= NW'(2))
  `CTWS_ASSERT_IMP(a_scan_index, state_r == S_EVAL, NW'(k_r) < n_r)
  `CTWS_ASSERT_IMP(a_emit_seeded, state_r == S_EMIT, best_valid_r)
  `CTWS_ASSERT_NXT(a_out_drop, out_valid_r && out_tready && state_r != S_EMIT,
                   !out_valid_r)

endmodule

`default_nettype wire
